>>> src/aecs_pkg.sv
// ----------------------------------------------------------------------------
// aecs_pkg
// Shared types and constants of the axis endstop calibration sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package aecs_pkg;

	localparam int unsigned PHASE_TIMEOUT_MS   = 60000;
	localparam int unsigned SEEK_DISTANCE      = 500000000;
	localparam int unsigned SLOW_FACTOR        = 5;
	localparam int unsigned SLOW_SEEK_RETREATS = 4;
	localparam int unsigned DEFAULT_RETREAT    = 1000;

	localparam int unsigned NUM_AXES     = 3;
	localparam int unsigned SPEED_W      = 27;
	localparam int unsigned SLOW_PROD_W  = 24 + 5;

	localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

	typedef enum logic [3:0] {
		PH_IDLE          = 4'd0,
		PH_SEEK_MIN_FAST = 4'd1,
		PH_RETREAT_MIN   = 4'd2,
		PH_SEEK_MIN_SLOW = 4'd3,
		PH_SEEK_MAX_FAST = 4'd4,
		PH_RETREAT_MAX   = 4'd5,
		PH_SEEK_MAX_SLOW = 4'd6,
		PH_PARK          = 4'd7,
		PH_DONE          = 4'd8,
		PH_FAILED        = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_ABORT = 3'd1,
		CMD_EDGE  = 3'd2,
		CMD_IDLE  = 3'd3,
		CMD_TICK  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE          = 3'd0,
		ACT_MOVE_REL      = 3'd1,
		ACT_MOVE_ABS      = 3'd2,
		ACT_FORCE_STOP    = 3'd3,
		ACT_STOP_ZERO     = 3'd4,
		ACT_RESTORE_SPEED = 3'd5,
		ACT_STOP_RESTORE  = 3'd6
	} act_t;

	localparam logic [1:0] AXIS_INVALID = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic [1:0]         axis;
		logic signed [31:0] park_position;
		logic [23:0]        retreat_distance;
		logic [23:0]        base_speed_us;
		logic [3:0]         pin;
		logic               switch_released;
		logic signed [31:0] position;
		logic               homing_busy;
	} item_t;

	typedef struct packed {
		phase_t             phase;
		logic [1:0]         cal_axis;
		logic signed [31:0] park_target;
		logic [23:0]        retreat_len;
		logic signed [31:0] span;
		logic               move_sent;
		logic [16:0]        elapsed_ms;
		logic [23:0]        saved_speed;
	} state_t;

	typedef struct packed {
		act_t               action;
		logic signed [31:0] move_distance;
		logic               set_speed;
		logic [SPEED_W-1:0] speed_interval;
		logic [1:0]         target_axis;
		phase_t             phase;
		logic               phase_changed;
		logic signed [31:0] span;
		logic               busy_res;
	} result_t;

	function automatic logic is_calibrating(phase_t p);
		return (p >= PH_SEEK_MIN_FAST) && (p <= PH_PARK);
	endfunction

endpackage

`default_nettype wire

>>> src/aecs_step.sv
// ----------------------------------------------------------------------------
// aecs_step
// Next-state and command logic for one event of the calibration sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module aecs_step
	import aecs_pkg::*;
#(
	parameter int unsigned TIMEOUT_MS  = PHASE_TIMEOUT_MS,
	parameter int unsigned SEEK_STEPS  = SEEK_DISTANCE,
	parameter int unsigned SLOW_MUL    = SLOW_FACTOR,
	parameter int unsigned RETREAT_MUL = SLOW_SEEK_RETREATS
)
(
	input  wire item_t                 item,
	input  wire state_t                st,
	input  wire logic [NUM_AXES-1:0][3:0] switch_pins,
	output state_t                     nxt,
	output result_t                    res
);

	logic [SLOW_PROD_W-1:0] slow_prod;
	logic [SPEED_W-1:0]     slow_speed;
	logic [31:0]            bound;
	logic [31:0]            seek_dist;
	logic [SPEED_W-1:0]     base_speed;
	logic                   edge_hit;
	logic [1:0]             edge_axis;
	logic                   changed;
	logic                   cal;

	assign slow_prod  = SLOW_PROD_W'(st.saved_speed) * SLOW_PROD_W'(SLOW_MUL);
	assign slow_speed = (slow_prod > SLOW_PROD_W'(SPEED_MAX)) ? SPEED_MAX :
		slow_prod[SPEED_W-1:0];
	assign bound      = 32'(st.retreat_len) * 32'(RETREAT_MUL);
	assign seek_dist  = 32'(SEEK_STEPS);
	assign base_speed = SPEED_W'(st.saved_speed);
	assign cal        = is_calibrating(st.phase);

	always_comb begin
		edge_hit  = 1'b0;
		edge_axis = 2'd0;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (switch_pins[i] == item.pin) begin
				edge_hit  = 1'b1;
				edge_axis = 2'(i);
			end
		end
	end

	always_comb begin
		nxt                = st;
		changed            = 1'b0;
		res.action         = ACT_NONE;
		res.move_distance  = '0;
		res.set_speed      = 1'b0;
		res.speed_interval = '0;

		case (item.command)
			CMD_START: begin
				if (item.axis != AXIS_INVALID && !cal && !item.homing_busy) begin
					nxt.cal_axis      = item.axis;
					nxt.park_target   = item.park_position;
					nxt.retreat_len   = (item.retreat_distance == '0) ?
						24'(DEFAULT_RETREAT) : item.retreat_distance;
					nxt.span          = '0;
					nxt.saved_speed   = item.base_speed_us;
					nxt.phase         = PH_SEEK_MIN_FAST;
					changed           = 1'b1;
				end
			end
			CMD_ABORT: begin
				if (cal) begin
					res.action         = ACT_STOP_RESTORE;
					res.set_speed      = 1'b1;
					res.speed_interval = base_speed;
					nxt.phase          = PH_FAILED;
					changed            = 1'b1;
				end
			end
			CMD_EDGE: begin
				if (!item.switch_released && edge_hit && edge_axis == st.cal_axis &&
					st.move_sent) begin
					case (st.phase)
						PH_SEEK_MIN_FAST: begin
							res.action = ACT_FORCE_STOP;
							nxt.phase  = PH_RETREAT_MIN;
							changed    = 1'b1;
						end
						PH_SEEK_MIN_SLOW: begin
							res.action = ACT_STOP_ZERO;
							nxt.phase  = PH_SEEK_MAX_FAST;
							changed    = 1'b1;
						end
						PH_SEEK_MAX_FAST: begin
							res.action = ACT_FORCE_STOP;
							nxt.phase  = PH_RETREAT_MAX;
							changed    = 1'b1;
						end
						PH_SEEK_MAX_SLOW: begin
							res.action = ACT_FORCE_STOP;
							nxt.span   = item.position;
							nxt.phase  = PH_PARK;
							changed    = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			CMD_IDLE: begin
				if (cal && !st.move_sent) begin
					nxt.move_sent = 1'b1;
					res.action    = ACT_MOVE_REL;
					case (st.phase)
						PH_SEEK_MIN_FAST: begin
							res.move_distance  = 32'd0 - seek_dist;
							res.set_speed      = 1'b1;
							res.speed_interval = base_speed;
						end
						PH_RETREAT_MIN: begin
							res.move_distance = 32'(st.retreat_len);
						end
						PH_SEEK_MIN_SLOW: begin
							res.move_distance  = 32'd0 - bound;
							res.set_speed      = 1'b1;
							res.speed_interval = slow_speed;
						end
						PH_SEEK_MAX_FAST: begin
							res.move_distance  = seek_dist;
							res.set_speed      = 1'b1;
							res.speed_interval = base_speed;
						end
						PH_RETREAT_MAX: begin
							res.move_distance = 32'd0 - 32'(st.retreat_len);
						end
						PH_SEEK_MAX_SLOW: begin
							res.move_distance  = bound;
							res.set_speed      = 1'b1;
							res.speed_interval = slow_speed;
						end
						default: begin
							res.action         = ACT_MOVE_ABS;
							res.move_distance  = st.park_target;
							res.set_speed      = 1'b1;
							res.speed_interval = base_speed;
						end
					endcase
				end else if (cal) begin
					case (st.phase)
						PH_RETREAT_MIN: begin
							nxt.phase = PH_SEEK_MIN_SLOW;
							changed   = 1'b1;
						end
						PH_RETREAT_MAX: begin
							nxt.phase = PH_SEEK_MAX_SLOW;
							changed   = 1'b1;
						end
						PH_PARK: begin
							res.action         = ACT_RESTORE_SPEED;
							res.set_speed      = 1'b1;
							res.speed_interval = base_speed;
							nxt.phase          = PH_DONE;
							changed            = 1'b1;
						end
						PH_SEEK_MIN_SLOW, PH_SEEK_MAX_SLOW: begin
							res.action         = ACT_STOP_RESTORE;
							res.set_speed      = 1'b1;
							res.speed_interval = base_speed;
							nxt.phase          = PH_FAILED;
							changed            = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			CMD_TICK: begin
				if (cal) begin
					if (st.elapsed_ms >= 17'(TIMEOUT_MS)) begin
						res.action         = ACT_STOP_RESTORE;
						res.set_speed      = 1'b1;
						res.speed_interval = base_speed;
						nxt.phase          = PH_FAILED;
						changed            = 1'b1;
					end else begin
						nxt.elapsed_ms = st.elapsed_ms + 17'd1;
					end
				end
			end
			default: begin
			end
		endcase

		if (changed) begin
			nxt.move_sent  = 1'b0;
			nxt.elapsed_ms = '0;
		end

		res.target_axis   = nxt.cal_axis;
		res.phase         = nxt.phase;
		res.phase_changed = changed;
		res.span          = nxt.span;
		res.busy_res      = is_calibrating(nxt.phase);
	end

endmodule

`default_nettype wire

>>> src/axis_endstop_calibration_sequencer.sv
// ----------------------------------------------------------------------------
// axis_endstop_calibration_sequencer
// Runs the endstop calibration sequence of one stepper axis, one command per event.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Contents
// in        sink       in_valid/in_ready    one event request
// out       source     out_valid/out_ready  stepper command and phase report
// cfg       sink       cfg_valid/cfg_ready  endstop pin of one axis
//
// An event request is registered, evaluated against the sequencer state and its
// result is registered at the output when the output is free or being read. One
// request is accepted every cycle while the output advances. A stalled output holds
// the evaluation stage, and the input stalls only once that stage is full. Reset
// clears the state and all endstop pins.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_endstop_calibration_sequencer
	import aecs_pkg::*;
#(
	parameter int unsigned TIMEOUT_MS  = PHASE_TIMEOUT_MS,
	parameter int unsigned SEEK_STEPS  = SEEK_DISTANCE,
	parameter int unsigned SLOW_MUL    = SLOW_FACTOR,
	parameter int unsigned RETREAT_MUL = SLOW_SEEK_RETREATS
)
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire logic [2:0]          command,
	input  wire logic [1:0]          axis,
	input  wire logic signed [31:0]  park_position,
	input  wire logic [23:0]         retreat_distance,
	input  wire logic [23:0]         base_speed_us,
	input  wire logic [3:0]          pin,
	input  wire logic                switch_released,
	input  wire logic signed [31:0]  position,
	input  wire logic                homing_busy,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [2:0]               action,
	output logic signed [31:0]       move_distance,
	output logic                     set_speed,
	output logic [SPEED_W-1:0]       speed_interval,
	output logic [1:0]               target_axis,
	output logic [3:0]               phase,
	output logic                     phase_changed,
	output logic signed [31:0]       span,
	output logic                     busy_res,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [3:0]          cfg_data
);

	logic                     valid_s1;
	item_t                    item_s1;
	state_t                   state_q;
	state_t                   state_nxt;
	result_t                  res_nxt;
	result_t                  res_q;
	logic                     out_valid_q;
	logic                     advance;
	logic [NUM_AXES-1:0][3:0] pins_q;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.command          <= command;
			item_s1.axis             <= axis;
			item_s1.park_position    <= park_position;
			item_s1.retreat_distance <= retreat_distance;
			item_s1.base_speed_us    <= base_speed_us;
			item_s1.pin              <= pin;
			item_s1.switch_released  <= switch_released;
			item_s1.position         <= position;
			item_s1.homing_busy      <= homing_busy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q <= '0;
		end else if (cfg_valid && cfg_index < 2'(NUM_AXES)) begin
			pins_q[cfg_index] <= cfg_data;
		end
	end

	aecs_step #(
		.TIMEOUT_MS  (TIMEOUT_MS),
		.SEEK_STEPS  (SEEK_STEPS),
		.SLOW_MUL    (SLOW_MUL),
		.RETREAT_MUL (RETREAT_MUL)
	) u_step (
		.item        (item_s1),
		.st          (state_q),
		.switch_pins (pins_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = res_q.action;
	assign move_distance  = res_q.move_distance;
	assign set_speed      = res_q.set_speed;
	assign speed_interval = res_q.speed_interval;
	assign target_axis    = res_q.target_axis;
	assign phase          = res_q.phase;
	assign phase_changed  = res_q.phase_changed;
	assign span           = res_q.span;
	assign busy_res       = res_q.busy_res;

endmodule

`default_nettype wire

>>> src/aecs_checker.sv
// ----------------------------------------------------------------------------
// aecs_checker
// Port-level checks of the calibration sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aecs_checker
	import aecs_pkg::*;
(
	input wire                     clk,
	input wire                     arst_n,
	input wire                     out_valid,
	input wire                     out_ready,
	input wire logic [2:0]         action,
	input wire logic signed [31:0] move_distance,
	input wire logic               set_speed,
	input wire logic [SPEED_W-1:0] speed_interval,
	input wire logic [3:0]         phase,
	input wire logic               phase_changed,
	input wire logic signed [31:0] span,
	input wire logic               busy_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) &&
		$stable(move_distance) && $stable(phase))
		else $error("Stalled result changed.");

	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_res == (phase >= PH_SEEK_MIN_FAST && phase <= PH_PARK))
		else $error("Busy flag disagrees with phase.");

	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !set_speed |-> speed_interval == '0)
		else $error("Speed interval without set_speed.");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_MOVE_REL && action != ACT_MOVE_ABS |->
		move_distance == '0)
		else $error("Move distance on a non-move action.");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_changed && phase == PH_SEEK_MIN_FAST |->
		action == ACT_NONE && span == '0)
		else $error("Calibration start did not clear the span.");

endmodule

bind axis_endstop_calibration_sequencer aecs_checker u_aecs_checker (.*);

`default_nettype wire

>>> tb/tb_axis_endstop_calibration_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axis_endstop_calibration_sequencer
// Self-checking testbench of the axis endstop calibration sequencer. A local
// model of the seven-phase sequence predicts the stepper command and phase
// report of every accepted request. Each result is compared field by field in
// order. Directed tests cover ignored requests, a complete calibration, abort
// and slow-seek failure. Mostly well-formed random sequences follow under
// several endstop pin settings, with random gaps and stalls in all but the last.
// ----------------------------------------------------------------------------

module tb_axis_endstop_calibration_sequencer;
	import aecs_pkg::*;

	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam int         MAX_REPORTS   = 50;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [2:0]               command;
	logic [1:0]               axis;
	logic signed [31:0]       park_position;
	logic [23:0]              retreat_distance;
	logic [23:0]              base_speed_us;
	logic [3:0]               pin;
	logic                     switch_released;
	logic signed [31:0]       position;
	logic                     homing_busy;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               action;
	logic signed [31:0]       move_distance;
	logic                     set_speed;
	logic [SPEED_W-1:0]       speed_interval;
	logic [1:0]               target_axis;
	logic [3:0]               phase;
	logic                     phase_changed;
	logic signed [31:0]       span;
	logic                     busy_res;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [1:0]               cfg_index;
	logic [3:0]               cfg_data;

	logic [3:0]               switch_pin [NUM_AXES];
	phase_t                   cur_phase;
	logic [1:0]               cur_axis;
	logic signed [31:0]       park_pos;
	logic [23:0]              retreat_len;
	logic signed [31:0]       span_val;
	logic                     move_out;
	logic [16:0]              elapsed;
	logic [23:0]              base_speed;

	result_t                  due_commands [$];
	int                       mismatch_count = 0;
	bit                       jitter = 1'b1;

	axis_endstop_calibration_sequencer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.axis             (axis),
		.park_position    (park_position),
		.retreat_distance (retreat_distance),
		.base_speed_us    (base_speed_us),
		.pin              (pin),
		.switch_released  (switch_released),
		.position         (position),
		.homing_busy      (homing_busy),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.action           (action),
		.move_distance    (move_distance),
		.set_speed        (set_speed),
		.speed_interval   (speed_interval),
		.target_axis      (target_axis),
		.phase            (phase),
		.phase_changed    (phase_changed),
		.span             (span),
		.busy_res         (busy_res),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[axis_endstop_calibration_sequencer] ERROR");
		$finish;
	end

	function automatic result_t next_stepper_command(input item_t it);
		result_t     cmd;
		phase_t      goal;
		logic        entered;
		logic        wrap;
		logic        wrap_ok;
		logic        active;
		logic [31:0] reach;
		logic [31:0] slow;
		int          hit;
		cmd     = '0;
		goal    = cur_phase;
		entered = 1'b0;
		wrap    = 1'b0;
		wrap_ok = 1'b0;
		active  = (cur_phase >= PH_SEEK_MIN_FAST) && (cur_phase <= PH_PARK);
		reach   = {8'd0, retreat_len} * SLOW_SEEK_RETREATS;
		slow    = {8'd0, base_speed} * SLOW_FACTOR;
		if (slow > 32'(SPEED_MAX))
			slow = 32'(SPEED_MAX);
		case (it.command)
			CMD_START: begin
				if (it.axis != AXIS_INVALID && !active && !it.homing_busy) begin
					cur_axis    = it.axis;
					park_pos    = it.park_position;
					retreat_len = (it.retreat_distance != 0) ? it.retreat_distance
						: 24'(DEFAULT_RETREAT);
					span_val    = '0;
					base_speed  = it.base_speed_us;
					goal        = PH_SEEK_MIN_FAST;
					entered     = 1'b1;
				end
			end
			CMD_ABORT: begin
				if (active)
					wrap = 1'b1;
			end
			CMD_EDGE: begin
				if (!it.switch_released) begin
					hit = -1;
					for (int i = 0; i < NUM_AXES; i++)
						if (switch_pin[i] == it.pin)
							hit = i;
					if (hit == int'(cur_axis) && move_out) begin
						case (cur_phase)
							PH_SEEK_MIN_FAST: begin
								cmd.action = ACT_FORCE_STOP;
								goal       = PH_RETREAT_MIN;
								entered    = 1'b1;
							end
							PH_SEEK_MIN_SLOW: begin
								cmd.action = ACT_STOP_ZERO;
								goal       = PH_SEEK_MAX_FAST;
								entered    = 1'b1;
							end
							PH_SEEK_MAX_FAST: begin
								cmd.action = ACT_FORCE_STOP;
								goal       = PH_RETREAT_MAX;
								entered    = 1'b1;
							end
							PH_SEEK_MAX_SLOW: begin
								cmd.action = ACT_FORCE_STOP;
								span_val   = it.position;
								goal       = PH_PARK;
								entered    = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			CMD_IDLE: begin
				if (active && !move_out) begin
					cmd.action = ACT_MOVE_REL;
					case (cur_phase)
						PH_SEEK_MIN_FAST: begin
							cmd.move_distance  = 32'(0 - SEEK_DISTANCE);
							cmd.set_speed      = 1'b1;
							cmd.speed_interval = SPEED_W'(base_speed);
						end
						PH_RETREAT_MIN:
							cmd.move_distance = 32'(retreat_len);
						PH_SEEK_MIN_SLOW: begin
							cmd.move_distance  = -reach;
							cmd.set_speed      = 1'b1;
							cmd.speed_interval = slow[SPEED_W-1:0];
						end
						PH_SEEK_MAX_FAST: begin
							cmd.move_distance  = SEEK_DISTANCE;
							cmd.set_speed      = 1'b1;
							cmd.speed_interval = SPEED_W'(base_speed);
						end
						PH_RETREAT_MAX:
							cmd.move_distance = -{8'd0, retreat_len};
						PH_SEEK_MAX_SLOW: begin
							cmd.move_distance  = reach;
							cmd.set_speed      = 1'b1;
							cmd.speed_interval = slow[SPEED_W-1:0];
						end
						default: begin
							cmd.action         = ACT_MOVE_ABS;
							cmd.move_distance  = park_pos;
							cmd.set_speed      = 1'b1;
							cmd.speed_interval = SPEED_W'(base_speed);
						end
					endcase
					move_out = 1'b1;
				end else if (active) begin
					case (cur_phase)
						PH_RETREAT_MIN: begin
							goal    = PH_SEEK_MIN_SLOW;
							entered = 1'b1;
						end
						PH_RETREAT_MAX: begin
							goal    = PH_SEEK_MAX_SLOW;
							entered = 1'b1;
						end
						PH_PARK: begin
							wrap    = 1'b1;
							wrap_ok = 1'b1;
						end
						PH_SEEK_MIN_SLOW, PH_SEEK_MAX_SLOW:
							wrap = 1'b1;
						default: ;
					endcase
				end
			end
			CMD_TICK: begin
				if (active) begin
					if (elapsed >= PHASE_TIMEOUT_MS)
						wrap = 1'b1;
					else
						elapsed = elapsed + 17'd1;
				end
			end
			default: ;
		endcase
		if (wrap) begin
			cmd.action         = wrap_ok ? ACT_RESTORE_SPEED : ACT_STOP_RESTORE;
			cmd.set_speed      = 1'b1;
			cmd.speed_interval = SPEED_W'(base_speed);
			goal               = wrap_ok ? PH_DONE : PH_FAILED;
			entered            = 1'b1;
		end
		if (entered) begin
			cur_phase = goal;
			move_out  = 1'b0;
			elapsed   = '0;
		end
		cmd.target_axis   = cur_axis;
		cmd.phase         = cur_phase;
		cmd.phase_changed = entered;
		cmd.span          = span_val;
		cmd.busy_res      = (cur_phase >= PH_SEEK_MIN_FAST) && (cur_phase <= PH_PARK);
		return cmd;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(negedge clk) begin : result_watch
		item_t   seen;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_AXES)
				switch_pin[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				seen = {command, axis, park_position, retreat_distance, base_speed_us, pin,
					switch_released, position, homing_busy};
				due_commands.push_back(next_stepper_command(seen));
			end
			if (out_valid && out_ready) begin
				if (due_commands.size() == 0) begin
					report_mismatch("result arrived with no request pending");
				end else begin
					want = due_commands.pop_front();
					check_field("action", action, want.action);
					check_field("move_distance", move_distance, want.move_distance);
					check_field("set_speed", set_speed, want.set_speed);
					check_field("speed_interval", speed_interval, want.speed_interval);
					check_field("target_axis", target_axis, want.target_axis);
					check_field("phase", phase, want.phase);
					check_field("phase_changed", phase_changed, want.phase_changed);
					check_field("span", span, want.span);
					check_field("busy_res", busy_res, want.busy_res);
				end
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (jitter && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic item_t event_of(input logic [2:0] c);
		item_t ev;
		ev.command         = c;
		ev.axis            = 2'($urandom_range(0, 2));
		ev.park_position   = $urandom;
		ev.pin             = 4'($urandom_range(0, 15));
		ev.switch_released = 1'b0;
		ev.position        = $urandom;
		ev.homing_busy     = 1'b0;
		case ($urandom_range(0, 7))
			0:       ev.retreat_distance = '0;
			1:       ev.retreat_distance = 24'hFFFFFF;
			default: ev.retreat_distance = 24'($urandom_range(1, 24'hFFFFFF));
		endcase
		case ($urandom_range(0, 7))
			0:       ev.base_speed_us = 24'd1;
			1:       ev.base_speed_us = 24'hFFFFFF;
			default: ev.base_speed_us = 24'($urandom_range(1, 24'hFFFFFF));
		endcase
		return ev;
	endfunction

	function automatic item_t noise_event();
		item_t ev;
		ev                 = event_of(3'($urandom_range(0, 7)));
		ev.axis            = 2'($urandom_range(0, 3));
		ev.homing_busy     = 1'($urandom_range(0, 1));
		ev.switch_released = 1'($urandom_range(0, 1));
		return ev;
	endfunction

	// Follows the sequence the block is in, so most requests move it forward.
	function automatic item_t wellformed_event();
		item_t ev;
		ev = event_of(CMD_TICK);
		if (!((cur_phase >= PH_SEEK_MIN_FAST) && (cur_phase <= PH_PARK))) begin
			ev.command     = CMD_START;
			ev.homing_busy = ($urandom_range(0, 15) == 0);
		end else if (!move_out) begin
			ev.command = CMD_IDLE;
		end else begin
			case (cur_phase)
				PH_RETREAT_MIN, PH_RETREAT_MAX, PH_PARK:
					ev.command = CMD_IDLE;
				default: begin
					if ((cur_phase == PH_SEEK_MIN_SLOW || cur_phase == PH_SEEK_MAX_SLOW)
							&& $urandom_range(0, 11) == 0) begin
						ev.command = CMD_IDLE;
					end else if ($urandom_range(0, 5) != 0) begin
						ev.command         = CMD_EDGE;
						ev.pin             = switch_pin[cur_axis];
						ev.switch_released = ($urandom_range(0, 7) == 0);
					end
				end
			endcase
		end
		return ev;
	endfunction

	task automatic send_event(input item_t ev);
		if (jitter && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		command          <= ev.command;
		axis             <= ev.axis;
		park_position    <= ev.park_position;
		retreat_distance <= ev.retreat_distance;
		base_speed_us    <= ev.base_speed_us;
		pin              <= ev.pin;
		switch_released  <= ev.switch_released;
		position         <= ev.position;
		homing_busy      <= ev.homing_busy;
		in_valid         <= 1'b1;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic await_drain();
		in_valid <= 1'b0;
		while (due_commands.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register i takes vals[4*i +: 4].
	task automatic write_pins(input logic [15:0] vals, input int count);
		for (int i = 0; i < count; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data  <= vals[4*i +: 4];
			@(negedge clk);
			while (!cfg_ready) @(negedge clk);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_ignored_events();
		item_t ev;
		send_event(event_of(CMD_ABORT));
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_TICK));
		ev = event_of(CMD_EDGE);
		ev.pin = 4'd0;
		send_event(ev);
		send_event(event_of(CMD_UNUSED_LO));
		send_event(event_of(CMD_UNUSED_HI));
		ev = event_of(CMD_START);
		ev.axis = AXIS_INVALID;
		send_event(ev);
		ev = event_of(CMD_START);
		ev.homing_busy = 1'b1;
		send_event(ev);
		await_drain();
	endtask

	task automatic test_full_calibration();
		item_t ev;
		// Axes 0 and 1 share a pin, so that pin belongs to axis 1. The last write
		// goes to an index past the last register.
		write_pins({4'd3, 4'd12, 4'd5, 4'd5}, NUM_AXES + 1);
		ev = event_of(CMD_START);
		ev.axis             = 2'd1;
		ev.park_position    = 32'sh80000000;
		ev.retreat_distance = '0;
		ev.base_speed_us    = 24'hFFFFFF;
		send_event(ev);
		ev = event_of(CMD_EDGE);
		ev.pin = 4'd5;
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_IDLE));
		ev.switch_released = 1'b1;
		send_event(ev);
		ev.switch_released = 1'b0;
		ev.pin             = 4'd12;
		send_event(ev);
		send_event(event_of(CMD_TICK));
		ev.pin = 4'd5;
		send_event(ev);
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_IDLE));
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_START));
		send_event(event_of(CMD_IDLE));
		ev.position = 32'sh7FFFFFFF;
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_ABORT));
		send_event(ev);
		await_drain();
	endtask

	task automatic test_abort_and_slow_failure();
		item_t ev;
		write_pins({4'd0, 4'd9, 4'd0, 4'd15}, NUM_AXES);
		ev = event_of(CMD_START);
		ev.axis             = 2'd0;
		ev.park_position    = 32'sh7FFFFFFF;
		ev.retreat_distance = 24'hFFFFFF;
		ev.base_speed_us    = 24'd1;
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_ABORT));
		send_event(event_of(CMD_TICK));
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		ev = event_of(CMD_EDGE);
		ev.pin = 4'd15;
		send_event(ev);
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_IDLE));
		send_event(event_of(CMD_IDLE));
		await_drain();
	endtask

	task automatic test_random_calibrations(input int count, input logic [15:0] pins);
		item_t ev;
		await_drain();
		write_pins(pins, NUM_AXES);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 199) == 0)
				await_drain();
			if ($urandom_range(0, 99) < 85)
				ev = wellformed_event();
			else
				ev = noise_event();
			send_event(ev);
		end
	endtask

	initial begin
		logic [3:0] p0;
		logic [3:0] p1;
		logic [3:0] p2;
		in_valid         <= 1'b0;
		command          <= CMD_START;
		axis             <= '0;
		park_position    <= '0;
		retreat_distance <= '0;
		base_speed_us    <= '0;
		pin              <= '0;
		switch_released  <= 1'b0;
		position         <= '0;
		homing_busy      <= 1'b0;
		cfg_valid        <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		arst_n           <= 1'b0;
		for (int i = 0; i < NUM_AXES; i++)
			switch_pin[i] = '0;
		cur_phase   = PH_IDLE;
		cur_axis    = '0;
		park_pos    = '0;
		retreat_len = '0;
		span_val    = '0;
		move_out    = 1'b0;
		elapsed     = '0;
		base_speed  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_ignored_events();
		test_full_calibration();
		test_abort_and_slow_failure();
		test_random_calibrations(400, {4'd0, 4'd8, 4'd15, 4'd0});
		test_random_calibrations(400, {4'd0, 4'd15, 4'd15, 4'd15});
		test_random_calibrations(400, {4'd0, 4'd0, 4'd4, 4'd9});
		p0 = 4'($urandom_range(0, 15));
		p1 = p0 + 4'($urandom_range(1, 7));
		p2 = p0 + 4'($urandom_range(8, 15));
		jitter = 1'b0;
		test_random_calibrations(350, {4'd0, p2, p1, p0});
		await_drain();

		if (mismatch_count == 0)
			$display("[axis_endstop_calibration_sequencer] OK");
		else
			$display("[axis_endstop_calibration_sequencer] ERROR");
		$finish;
	end

endmodule
